/* hw/rtl/hlse_pkg.sv */
`timescale 1ns / 1ps

package hlse_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FRAC_BITS_DEF = 15;

  // quotient bits retired by the shared divider in one cycle
  localparam int DIV_BITS = 4;

  localparam int X_W       = 16;
  localparam int SUM_OUT_W = 16;
  localparam int ADDED_W   = 7;
  localparam int TC_W      = 4;
  localparam int EPS_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int Q15_FRAC  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_MODE  = 2'd0,
    REG_TERM_COUNT = 2'd1,
    REG_EPSILON    = 2'd2
  } reg_idx_e;

  localparam logic             STOP_MODE_RST  = 1'b0;
  localparam logic [TC_W-1:0]  TERM_COUNT_RST = 4'd5;
  localparam logic [EPS_W-1:0] EPSILON_RST    = 12'd33;

  typedef struct packed {
    logic             stop_mode;
    logic [TC_W-1:0]  term_count;
    logic [EPS_W-1:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic [X_W-1:0] x_value;
  } x_item_t;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] series_sum;
    logic [ADDED_W-1:0]          terms_added;
    logic                        cap_reached;
  } result_t;

  typedef struct packed {
    logic load;
    logic take_z;
    logic mul_sq;
    logic rnd_zsq;
    logic mul;
    logic rnd_pw;
    logic acc;
    logic set_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_limit;
    logic last;
    logic le_eps;
    logic eps_mode;
  } status_t;

endpackage

/* hw/rtl/hlse_if.sv */
`timescale 1ns / 1ps

interface hlse_in_if;
  logic              valid;
  logic              ready;
  hlse_pkg::x_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hlse_out_if;
  logic              valid;
  logic              ready;
  hlse_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hlse_div.sv */
`timescale 1ns / 1ps

module hlse_div #(
  parameter int QW = 16,
  parameter int DW = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);
  import hlse_pkg::*;

  localparam int NW   = QW + DW;
  localparam int N_IT = QW / DIV_BITS;
  localparam int CW   = (N_IT > 1) ? $clog2(N_IT) : 1;
  localparam logic [CW-1:0] LAST = CW'(N_IT - 1);

  logic [DW-1:0] rem_q, rem_n;
  logic [DW-1:0] den_q;
  logic [QW-1:0] sh_q, sh_n;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  // restoring steps; the partial remainder stays below the divisor
  always_comb begin
    logic [DW:0] trial;
    rem_n = rem_q;
    sh_n  = sh_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_n, sh_n[QW-1]} - {1'b0, den_q};
      if (!trial[DW]) begin
        rem_n = trial[DW-1:0];
        sh_n  = {sh_n[QW-2:0], 1'b1};
      end else begin
        rem_n = {rem_n[DW-2:0], sh_n[QW-1]};
        sh_n  = {sh_n[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NW-1:QW];
      sh_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      sh_q  <= sh_n;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

/* hw/rtl/hlse_dp.sv */
`timescale 1ns / 1ps

module hlse_dp #(
  parameter int MAX_TERMS = hlse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = hlse_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hlse_pkg::X_W-1:0]      x_value_i,
  input  hlse_pkg::cfg_t                cfg_i,
  input  hlse_pkg::cmd_t                cmd_i,
  output hlse_pkg::status_t             st_o,
  output hlse_pkg::result_t             res_o
);
  import hlse_pkg::*;

  localparam int ZW    = FRAC_BITS + 1;
  localparam int XI_W  = FRAC_BITS + 2;
  localparam int DW    = FRAC_BITS + 2;
  localparam int QW    = ((FRAC_BITS + 1 + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int NW    = QW + DW;
  localparam int PW2   = 2 * ZW;
  localparam int SUM_W = FRAC_BITS + 8;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int D_W   = CNT_W + 2;
  localparam int CV_W  = FRAC_BITS + X_W + 1;
  localparam int MAG_W = 24;

  localparam int IN_UP  = (FRAC_BITS >= Q15_FRAC) ? FRAC_BITS - Q15_FRAC : 0;
  localparam int IN_DN  = (FRAC_BITS < Q15_FRAC) ? Q15_FRAC - FRAC_BITS : 0;
  localparam logic [CV_W-1:0] IN_HALF = CV_W'((64'd1 << IN_DN) >> 1);
  localparam logic [SUM_W:0]  OUT_HALF = (SUM_W + 1)'((64'd1 << IN_UP) >> 1);

  localparam logic [XI_W-1:0]  ONE      = XI_W'(1) << FRAC_BITS;
  localparam logic [PW2-1:0]   RND_HALF = PW2'(1) << (FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_TERMS);
  localparam logic [MAG_W-1:0] NEG_LIM  = MAG_W'(1) << (SUM_OUT_W - 1);
  localparam logic [MAG_W-1:0] POS_LIM  = NEG_LIM - MAG_W'(1);

  logic [CV_W-1:0]  x_wide, eps_wide;
  logic [XI_W-1:0]  xi, diff, den;
  logic [ZW-1:0]    eps_int;
  logic             neg;
  logic [NW-1:0]    div_num;
  logic [DW-1:0]    div_den;
  logic [D_W-1:0]   d;
  logic [QW-1:0]    quo;
  logic             div_done;
  logic [ZW-1:0]    term;
  logic [ZW-1:0]    mul_b;
  logic [PW2-1:0]   prod_d, prod_q;
  logic [ZW-1:0]    rnd;
  logic [ZW-1:0]    pw_q, zsq_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] added_q, limit;
  logic             cap_q, neg_q;
  logic [SUM_W:0]   sum_rnd;
  logic [MAG_W-1:0] mag, mag_sat;
  result_t          res_d, res_q;

  // Q1.15 inputs to the internal fraction width, rounded half up
  always_comb begin
    x_wide   = ((CV_W'(x_value_i) << IN_UP) + IN_HALF) >> IN_DN;
    eps_wide = ((CV_W'(cfg_i.epsilon) << IN_UP) + IN_HALF) >> IN_DN;
    xi       = XI_W'(x_wide);
    eps_int  = ZW'(eps_wide);
    neg      = (xi < ONE);
    diff     = neg ? (ONE - xi) : (xi - ONE);
    den      = xi + ONE;
  end

  always_comb begin
    if (cfg_i.stop_mode) begin
      limit = MAX_CNT;
    end else if (int'(cfg_i.term_count) > MAX_TERMS) begin
      limit = MAX_CNT;
    end else begin
      limit = CNT_W'(cfg_i.term_count);
    end
  end

  assign rnd = ZW'((prod_q + RND_HALF) >> FRAC_BITS);
  assign d   = (D_W'(added_q) << 1) + D_W'(3);

  // z numerator at load, otherwise the next term over its odd divisor
  always_comb begin
    if (cmd_i.load) begin
      div_num = (NW'(diff) << FRAC_BITS) + NW'(den >> 1);
      div_den = den;
    end else begin
      div_num = NW'(rnd) + NW'(added_q) + NW'(1);
      div_den = DW'(d);
    end
  end

  hlse_div #(
    .QW (QW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load | cmd_i.rnd_pw),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign term   = ZW'(quo);
  assign mul_b  = cmd_i.mul_sq ? pw_q : zsq_q;
  assign prod_d = pw_q * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= neg;
    end
    if (cmd_i.mul_sq || cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.take_z) begin
      pw_q  <= term;
      sum_q <= SUM_W'(term);
    end else if (cmd_i.rnd_pw) begin
      pw_q <= rnd;
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + SUM_W'(term);
    end
    if (cmd_i.rnd_zsq) begin
      zsq_q <= rnd;
    end
    if (cmd_i.out_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      added_q <= '0;
      cap_q   <= 1'b0;
    end else if (cmd_i.load) begin
      added_q <= '0;
      cap_q   <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        added_q <= added_q + CNT_W'(1);
      end
      if (cmd_i.set_cap) begin
        cap_q <= 1'b1;
      end
    end
  end

  // back to Q1.15 with rounding, then saturate on the sign of z
  always_comb begin
    sum_rnd = ((SUM_W + 1)'(sum_q) + OUT_HALF) >> IN_UP;
    mag     = MAG_W'(sum_rnd) << IN_DN;
    if (neg_q) begin
      mag_sat = (mag > NEG_LIM) ? NEG_LIM : mag;
      res_d.series_sum = SUM_OUT_W'(MAG_W'(0) - mag_sat);
    end else begin
      mag_sat = (mag > POS_LIM) ? POS_LIM : mag;
      res_d.series_sum = SUM_OUT_W'(mag_sat);
    end
    res_d.terms_added = ADDED_W'(added_q);
    res_d.cap_reached = cap_q;
  end

  always_comb begin
    st_o.div_done = div_done;
    st_o.at_limit = (added_q == limit);
    st_o.last     = ((CNT_W + 1)'(added_q) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(limit);
    st_o.le_eps   = (term <= eps_int);
    st_o.eps_mode = cfg_i.stop_mode;
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/hlse_ctrl.sv */
`timescale 1ns / 1ps

module hlse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  hlse_pkg::status_t st_i,
  output hlse_pkg::cmd_t    cmd_o
);
  import hlse_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZDIV,
    ST_ZSQ_MUL,
    ST_ZSQ_RND,
    ST_MUL,
    ST_RND,
    ST_TDIV,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ZDIV;
        end
      end
      ST_ZDIV: begin
        if (st_i.div_done) begin
          cmd_o.take_z = 1'b1;
          state_d      = ST_ZSQ_MUL;
        end
      end
      ST_ZSQ_MUL: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ST_ZSQ_RND;
      end
      ST_ZSQ_RND: begin
        cmd_o.rnd_zsq = 1'b1;
        state_d       = st_i.at_limit ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_pw = 1'b1;
        state_d      = ST_TDIV;
      end
      ST_TDIV: begin
        if (st_i.div_done) begin
          cmd_o.acc = 1'b1;
          if (st_i.eps_mode && st_i.le_eps) begin
            state_d = ST_FIN;
          end else if (st_i.last) begin
            cmd_o.set_cap = st_i.eps_mode;
            state_d       = ST_FIN;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/half_log_series_evaluator.sv */
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// in_i      in   in_i.valid/ready     x_value     unsigned Q1.15
// out_o     out  out_o.valid/ready    series_sum  signed Q1.15,
//                                     terms_added, cap_reached
// cfg       in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// One item at a time. The shared divider retires four quotient bits a cycle;
// an item runs a division for z, the square of z and its rounding, then for
// each further term a multiply, a rounding and a division, and the result is
// stored. in_i.ready returns in the cycle after the result is stored.
// The result sits in an output register; a new item is accepted while it
// waits, and only the final store stalls on a full output register.
// Reset is asynchronous, active low, and restores the register defaults.

module half_log_series_evaluator #(
  parameter int MAX_TERMS = hlse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = hlse_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hlse_in_if.sink                        in_i,
  hlse_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [hlse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hlse_pkg::CFG_W-1:0]     cfg_data_i
);
  import hlse_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_mode  <= STOP_MODE_RST;
      cfg_q.term_count <= TERM_COUNT_RST;
      cfg_q.epsilon    <= EPSILON_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STOP_MODE:  cfg_q.stop_mode  <= cfg_data_i[0];
        REG_TERM_COUNT: cfg_q.term_count <= cfg_data_i[TC_W-1:0];
        REG_EPSILON:    cfg_q.epsilon    <= cfg_data_i[EPS_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  hlse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  hlse_dp #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .x_value_i (in_i.data.x_value),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd),
    .st_o      (st),
    .res_o     (out_o.data)
  );

endmodule

/* hw/rtl/hlse_checker.sv */
`timescale 1ns / 1ps

module hlse_props #(
  parameter int MAX_TERMS = hlse_pkg::MAX_TERMS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hlse_pkg::result_t out_data_i
);
  import hlse_pkg::*;

  localparam logic [ADDED_W-1:0] MAX_ADDED = ADDED_W'(MAX_TERMS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_terms_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.terms_added <= MAX_ADDED)
    else $error("terms_added beyond the term cap");

  a_cap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.cap_reached |-> out_data_i.terms_added == MAX_ADDED)
    else $error("cap flag without the full term count");

endmodule

bind half_log_series_evaluator hlse_props #(
  .MAX_TERMS (MAX_TERMS)
) u_hlse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
